FILE: rtl/mqtt_receive_deframer_macros.svh
// Assertion macros for the MQTT receive deframer.
// Needs nothing else; taken in by the files that assert.
`ifndef MQTT_RECEIVE_DEFRAMER_MACROS_SVH
`define MQTT_RECEIVE_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MRD_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/mrd_pkg.sv
// Shared types and constants of the MQTT receive deframer.
// Used by the channel interfaces and the top level; depends on nothing.
package mrd_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       part;
    logic       byte_valid;
    logic       topic_end;
    logic       message_end;
    logic       malformed;
  } msg_t;

  localparam logic [3:0]  KindPublish    = 4'd3;
  localparam logic [1:0]  LenShiftLast   = 2'd3;
  localparam logic [27:0] MinPublishBody = 28'd2;

endpackage

FILE: rtl/mrd_if.sv
// Valid/ready channel interfaces of the MQTT receive deframer.
// Depends on mrd_pkg for the result word type.
interface mqtt_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mqtt_msg_if;
  mrd_pkg::msg_t payload;
  logic          valid;
  logic          ready;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/mqtt_receive_deframer.sv
// MQTT 3.1.1 receive deframer: byte-serial framing state machine, output skid.
// Depends on mrd_pkg, mrd_if.sv and mqtt_receive_deframer_macros.svh.
//
// Usage:
//  rx  (sink)  : one received broker byte per word.
//  msg (source): at most one result word per received byte: a topic or
//                payload byte with its part, topic end and message end marks,
//                a byteless message end for an empty message, or a single
//                malformed word when the length field overruns four bytes.
//  Results are registered. Throughput: one byte per cycle while rx is ready,
//  set by the single framing state update.
//  Stall: an output register and a one-word skid register sit behind the
//  state machine, so rx stays ready while one result waits; rx drops ready
//  only once both are full, and no result is lost or repeated.
//  Reset (rst, synchronous, active high): framing restarts at a type byte,
//  both result registers empty. After a malformed word the block keeps
//  taking bytes but discards them until reset.
`include "mqtt_receive_deframer_macros.svh"

module mqtt_receive_deframer (
  input logic  clk,
  input logic  rst,
  mqtt_rx_if.sink    rx,
  mqtt_msg_if.source msg
);
  import mrd_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN,
    PH_TOPIC_HI,
    PH_TOPIC_LO,
    PH_TOPIC,
    PH_PAYLOAD,
    PH_SKIP,
    PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  packet_kind, packet_kind_next;
  logic [27:0] body_left, body_left_next;
  logic [1:0]  length_shift, length_shift_next;
  logic [15:0] topic_left, topic_left_next;
  logic [7:0]  topic_high, topic_high_next;

  logic        out_valid, skid_valid;
  msg_t        out_word, skid_word;

  logic        accept, take, res_fire;
  msg_t        res;
  logic [27:0] len_group, body_dec;
  logic [15:0] topic_field, topic_dec;

  assign accept    = rx.valid && rx.ready;
  assign take      = out_valid && msg.ready;
  assign rx.ready  = !skid_valid;
  assign msg.valid = out_valid;
  assign msg.payload = out_word;

  assign body_dec    = body_left - 28'd1;
  assign topic_dec   = topic_left - 16'd1;
  assign topic_field = {topic_high, rx.rx_byte};

  always_comb begin
    case (length_shift)
      2'd0:    len_group = {21'd0, rx.rx_byte[6:0]};
      2'd1:    len_group = {14'd0, rx.rx_byte[6:0], 7'd0};
      2'd2:    len_group = {7'd0, rx.rx_byte[6:0], 14'd0};
      default: len_group = {rx.rx_byte[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_next        = phase;
    packet_kind_next  = packet_kind;
    body_left_next    = body_left;
    length_shift_next = length_shift;
    topic_left_next   = topic_left;
    topic_high_next   = topic_high;
    res_fire          = 1'b0;
    res               = '0;
    case (phase)
      PH_TYPE: begin
        packet_kind_next  = rx.rx_byte[7:4];
        body_left_next    = '0;
        length_shift_next = '0;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        body_left_next = body_left | len_group;
        if (rx.rx_byte[7]) begin
          if (length_shift == LenShiftLast) begin
            phase_next    = PH_HALT;
            res_fire      = 1'b1;
            res.malformed = 1'b1;
          end else begin
            length_shift_next = length_shift + 2'd1;
          end
        end else if (packet_kind == KindPublish && body_left_next >= MinPublishBody) begin
          phase_next = PH_TOPIC_HI;
        end else begin
          phase_next = (body_left_next != '0) ? PH_SKIP : PH_TYPE;
        end
      end
      PH_TOPIC_HI: begin
        topic_high_next = rx.rx_byte;
        body_left_next  = body_dec;
        phase_next      = PH_TOPIC_LO;
      end
      PH_TOPIC_LO: begin
        body_left_next  = body_dec;
        topic_left_next = topic_field;
        if ({12'd0, topic_field} > body_dec) begin
          // oversize topic: drop the rest of the body
          topic_left_next = '0;
          phase_next      = (body_dec != '0) ? PH_SKIP : PH_TYPE;
        end else if (topic_field != '0) begin
          phase_next = PH_TOPIC;
        end else if (body_dec != '0) begin
          phase_next = PH_PAYLOAD;
        end else begin
          phase_next      = PH_TYPE;
          res_fire        = 1'b1;
          res.message_end = 1'b1;
        end
      end
      PH_TOPIC: begin
        topic_left_next = topic_dec;
        body_left_next  = body_dec;
        res_fire        = 1'b1;
        res.data        = rx.rx_byte;
        res.byte_valid  = 1'b1;
        res.topic_end   = (topic_dec == '0);
        res.message_end = (topic_dec == '0) && (body_dec == '0);
        if (res.message_end) begin
          phase_next = PH_TYPE;
        end else if (res.topic_end) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        body_left_next  = body_dec;
        res_fire        = 1'b1;
        res.data        = rx.rx_byte;
        res.part        = 1'b1;
        res.byte_valid  = 1'b1;
        res.message_end = (body_dec == '0);
        if (body_dec == '0) begin
          phase_next = PH_TYPE;
        end
      end
      PH_SKIP: begin
        body_left_next = body_dec;
        if (body_dec == '0) begin
          phase_next = PH_TYPE;
        end
      end
      default: begin
        // halted: swallow every byte
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      packet_kind  <= '0;
      body_left    <= '0;
      length_shift <= '0;
      topic_left   <= '0;
      topic_high   <= '0;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        packet_kind  <= packet_kind_next;
        body_left    <= body_left_next;
        length_shift <= length_shift_next;
        topic_left   <= topic_left_next;
        topic_high   <= topic_high_next;
      end
      if (accept && res_fire) begin
        // skid is empty whenever rx is ready
        if (!out_valid || take) begin
          out_word  <= res;
          out_valid <= 1'b1;
        end else begin
          skid_word  <= res;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  `MRD_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid,
                    "skid word held with empty output register")
  `MRD_ASSERT_IMPLY(a_malformed_halts, clk, rst, out_valid && out_word.malformed,
                    phase == PH_HALT, "malformed word offered while not halted")
  `MRD_ASSERT_NEXT(a_halt_sticks, clk, rst, phase == PH_HALT, phase == PH_HALT,
                   "left halt without reset")
  `MRD_ASSERT_IMPLY(a_byteless_clean, clk, rst, out_valid && !out_word.byte_valid,
                    out_word.data == 8'd0 && !out_word.part && !out_word.topic_end,
                    "byteless word carries data")

endmodule

FILE: tb/mqtt_receive_deframer_test.sv
// Self-checking bench for the MQTT receive deframer: random byte streams of
// framed packets go in, deframed topic and payload words are checked against
// a cycle-free framing model. Depends on mrd_pkg, mrd_if.sv and the top level.
module mqtt_receive_deframer_test;
  import mrd_pkg::*;

  localparam int unsigned RandomBytes = 1950;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 400000;

  typedef enum logic [2:0] {
    AwaitType, AwaitLength, AwaitTopicHigh, AwaitTopicLow,
    InTopic, InPayload, Skipping, Halted
  } frame_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  mqtt_rx_if  rx_ch ();
  mqtt_msg_if msg_ch ();

  mqtt_receive_deframer dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .msg (msg_ch)
  );

  logic       byte_offered = 1'b0;
  logic [7:0] rx_data      = 8'h00;
  logic       sink_ready   = 1'b0;

  assign rx_ch.valid   = byte_offered;
  assign rx_ch.rx_byte = rx_data;
  assign msg_ch.ready  = sink_ready;

  logic [7:0]  tx_bytes [$];
  msg_t        due_msgs [$];
  int unsigned total_bytes = 0;
  int unsigned hold_from   = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Handshake records, updated at the rising edge only.
  logic        byte_taken  = 1'b0;
  logic        word_taken  = 1'b0;
  int unsigned bytes_taken = 0;

  // Framing model state.
  frame_phase_t fr_phase    = AwaitType;
  logic [3:0]   fr_kind     = '0;
  logic [27:0]  fr_body     = '0;
  logic [1:0]   fr_shift    = '0;
  logic [15:0]  fr_topic    = '0;
  logic [7:0]   fr_topic_hi = '0;

  task automatic report_mismatch(input string what);
    $display("cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Append a byte to the send queue.
  task automatic add_byte(input logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endtask

  // Append a word to the expected results.
  task automatic add_due(input msg_t w);
    due_msgs.insert(due_msgs.size(), w);
  endtask

  task automatic drop_body();
    fr_phase = (fr_body != 0) ? Skipping : AwaitType;
  endtask

  // Advance the framing model by one byte; queue the word it yields, if any.
  task automatic deframe_byte(input logic [7:0] b);
    msg_t w;
    w = '0;
    case (fr_phase)
      AwaitType: begin
        fr_kind  = b[7:4];
        fr_body  = '0;
        fr_shift = '0;
        fr_phase = AwaitLength;
      end
      AwaitLength: begin
        fr_body = fr_body | ({21'd0, b[6:0]} << (7 * fr_shift));
        if (b[7]) begin
          if (fr_shift == LenShiftLast) begin
            fr_phase    = Halted;
            w.malformed = 1'b1;
            add_due(w);
          end else begin
            fr_shift = fr_shift + 2'd1;
          end
        end else if (fr_kind == KindPublish && fr_body >= MinPublishBody) begin
          fr_phase = AwaitTopicHigh;
        end else begin
          drop_body();
        end
      end
      AwaitTopicHigh: begin
        fr_topic_hi = b;
        fr_body     = fr_body - 28'd1;
        fr_phase    = AwaitTopicLow;
      end
      AwaitTopicLow: begin
        fr_body  = fr_body - 28'd1;
        fr_topic = {fr_topic_hi, b};
        if ({12'd0, fr_topic} > fr_body) begin
          fr_topic = '0;
          drop_body();
        end else if (fr_topic != 0) begin
          fr_phase = InTopic;
        end else if (fr_body != 0) begin
          fr_phase = InPayload;
        end else begin
          // empty message: a lone end mark
          fr_phase      = AwaitType;
          w.message_end = 1'b1;
          add_due(w);
        end
      end
      InTopic: begin
        fr_topic      = fr_topic - 16'd1;
        fr_body       = fr_body - 28'd1;
        w.data        = b;
        w.byte_valid  = 1'b1;
        w.topic_end   = (fr_topic == 0);
        w.message_end = w.topic_end && (fr_body == 0);
        if (w.message_end) fr_phase = AwaitType;
        else if (w.topic_end) fr_phase = InPayload;
        add_due(w);
      end
      InPayload: begin
        fr_body       = fr_body - 28'd1;
        w.data        = b;
        w.part        = 1'b1;
        w.byte_valid  = 1'b1;
        w.message_end = (fr_body == 0);
        if (w.message_end) fr_phase = AwaitType;
        add_due(w);
      end
      Skipping: begin
        fr_body = fr_body - 28'd1;
        if (fr_body == 0) fr_phase = AwaitType;
      end
      default: ;
    endcase
  endtask

  // Remaining length, seven bits per byte, low group first; pad with empty groups.
  task automatic push_length(input int unsigned len, input int unsigned pad);
    int unsigned groups;
    logic [6:0]  grp;
    logic        more;
    groups = 1;
    while (groups < 4 && (len >> (7 * groups)) != 0) groups++;
    groups = groups + pad;
    if (groups > 4) groups = 4;
    for (int i = 0; i < groups; i++) begin
      grp  = 7'((len >> (7 * i)) & 'h7f);
      more = (i + 1 < groups);
      add_byte({more, grp});
    end
  endtask

  task automatic queue_raw(input logic [7:0] head, input int unsigned body_n,
                           input int unsigned pad);
    add_byte(head);
    push_length(body_n, pad);
    repeat (body_n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_publish(input logic [15:0] topic_field, input int unsigned rest_n,
                               input int unsigned pad);
    add_byte({KindPublish, 4'($urandom_range(0, 15))});
    push_length(rest_n + 2, pad);
    add_byte(topic_field[15:8]);
    add_byte(topic_field[7:0]);
    repeat (rest_n) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Sender: one byte per handshake, random gap before each.
  int unsigned send_gap  = 0;
  logic        send_calm = 1'b0;

  always @(negedge clk) begin : drive_rx
    if (rst) begin
      byte_offered <= 1'b0;
    end else if (!byte_offered || byte_taken) begin
      if (send_gap != 0) begin
        send_gap     <= send_gap - 1;
        byte_offered <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        rx_data      <= tx_bytes.pop_front();
        byte_offered <= 1'b1;
        send_gap     <= send_calm ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 49) == 0) send_calm <= !send_calm;
      end else begin
        byte_offered <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, so that the result buffers fill and rx stalls.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk) begin : hold_off
    if (!rst && !hold_done && bytes_taken == hold_from) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: after each word taken, wait a random number of cycles.
  int unsigned recv_wait = 0;
  logic        recv_calm = 1'b0;

  always @(negedge clk) begin : drive_msg_ready
    int unsigned w;
    if (rst || hold_left != 0) begin
      sink_ready <= 1'b0;
    end else begin
      if (word_taken) begin
        w = recv_calm ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 49) == 0) recv_calm <= !recv_calm;
      end else begin
        w = recv_wait;
      end
      if (w != 0) begin
        sink_ready <= 1'b0;
        recv_wait  <= w - 1;
      end else begin
        sink_ready <= 1'b1;
        recv_wait  <= 0;
      end
    end
  end

  always @(posedge clk) begin : watch
    msg_t want;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) deframe_byte(rx_ch.rx_byte);
      if (msg_ch.valid && msg_ch.ready) begin
        if (due_msgs.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", msg_ch.payload));
        end else begin
          want = due_msgs.pop_front();
          check_field("data", msg_ch.payload.data, want.data);
          check_field("part", msg_ch.payload.part, want.part);
          check_field("byte_valid", msg_ch.payload.byte_valid, want.byte_valid);
          check_field("topic_end", msg_ch.payload.topic_end, want.topic_end);
          check_field("message_end", msg_ch.payload.message_end, want.message_end);
          check_field("malformed", msg_ch.payload.malformed, want.malformed);
        end
      end
    end
    byte_taken <= !rst && rx_ch.valid && rx_ch.ready;
    word_taken <= !rst && msg_ch.valid && msg_ch.ready;
    if (!rst && rx_ch.valid && rx_ch.ready) bytes_taken <= bytes_taken + 1;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("mqtt_receive_deframer_test: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  opening [29];
    int unsigned pick;
    int unsigned topic_n;
    int unsigned payload_n;
    int unsigned rest_n;
    int unsigned pad;
    int unsigned kind;

    opening = '{
      8'h30, 8'h02, 8'h00, 8'h00,                // empty message
      8'h31, 8'h03, 8'h00, 8'h00, 8'hFF,         // empty topic, one payload byte
      8'h3F, 8'h03, 8'h00, 8'h01, 8'h00,         // one topic byte, empty payload
      8'h30, 8'h01, 8'hAA,                       // publish body too short
      8'hF0, 8'h00, 8'h30, 8'h00,                // zero-length bodies
      8'h3B, 8'h83, 8'h80, 8'h80, 8'h00,         // four-byte length of 3 ...
      8'hFF, 8'hFF, 8'h55                        // ... topic length oversize
    };
    foreach (opening[i]) add_byte(opening[i]);

    // Receiver holds off as the topic of this long message starts.
    hold_from = tx_bytes.size() + 4;
    queue_publish(16'd4, 64, 0);

    while (tx_bytes.size() < RandomBytes) begin
      pick = $urandom_range(0, 99);
      pad  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      if (pick < 55) begin
        topic_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 19) == 0) payload_n = $urandom_range(120, 140);
        else if ($urandom_range(0, 4) == 0) payload_n = 0;
        else payload_n = $urandom_range(1, 12);
        queue_publish(16'(topic_n), topic_n + payload_n, pad);
      end else if (pick < 62) begin
        queue_raw({KindPublish, 4'($urandom_range(0, 15))}, $urandom_range(0, 1), pad);
      end else if (pick < 68) begin
        rest_n = $urandom_range(0, 10);
        queue_publish(16'($urandom_range(rest_n + 1, 65535)), rest_n, pad);
      end else if (pick < 85) begin
        kind = $urandom_range(0, 14);
        if (kind >= KindPublish) kind++;
        queue_raw({4'(kind), 4'($urandom_range(0, 15))}, $urandom_range(0, 8), pad);
      end else begin
        queue_raw(8'($urandom_range(0, 255)), $urandom_range(0, 10), pad);
      end
    end

    // Length overrun last: the block halts and ignores what follows.
    add_byte(8'($urandom_range(0, 255)));
    repeat (4) add_byte({1'b1, 7'($urandom_range(0, 127))});
    repeat (6) add_byte(8'($urandom_range(0, 255)));
    total_bytes = tx_bytes.size();

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (bytes_taken != total_bytes) @(negedge clk);
    while (due_msgs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("mqtt_receive_deframer_test: done, clean");
    end else begin
      $display("mqtt_receive_deframer_test: done, errors");
    end
    $finish;
  end

endmodule
